/* sv/tepr_pkg.sv */
// Shared types and codes for the TCP endpoint rewrite table.
// Used by every module of the block; depends on nothing.
package tepr_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_INCOMING = 2'd1;
  localparam logic [1:0] ACT_OUTGOING = 2'd2;

  // Verdict codes of a result item
  localparam logic [2:0] V_PASS     = 3'd0;
  localparam logic [2:0] V_REWRITE  = 3'd1;
  localparam logic [2:0] V_DROP     = 3'd2;
  localparam logic [2:0] V_INSERTED = 3'd3;
  localparam logic [2:0] V_FULL     = 3'd4;

  // One endpoint: address over port, as kept in the stores
  localparam int EP_W = 48;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic        is_tcp;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    logic [31:0] orig_addr;
    logic [15:0] orig_port;
    logic [31:0] repl_addr;
    logic [15:0] repl_port;
  } tepr_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic [15:0] out_ip_csum;
    logic [15:0] out_tcp_csum;
    logic [7:0]  entry_total;
  } tepr_out_t;

  // Handshake between the sequencer and the checksum unit
  typedef struct packed {
    logic        start;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    logic [31:0] from_addr;
    logic [15:0] from_port;
    logic [31:0] to_addr;
    logic [15:0] to_port;
  } tepr_cs_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tepr_cs_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CSUM
  } tepr_state_t;

endpackage

/* sv/tepr_store.sv */
// Entry store: old and new endpoint memories sharing one address space.
// One write port, one read port with registered read data. Uses tepr_pkg.
module tepr_store #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [tepr_pkg::EP_W-1:0]  wr_old,
  input  logic [tepr_pkg::EP_W-1:0]  wr_new,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [tepr_pkg::EP_W-1:0]  rd_old,
  output logic [tepr_pkg::EP_W-1:0]  rd_new
);
  import tepr_pkg::*;

  logic [EP_W-1:0] old_mem [DEPTH];
  logic [EP_W-1:0] new_mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      old_mem[wr_addr] <= wr_old;
      new_mem[wr_addr] <= wr_new;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_old <= old_mem[rd_addr];
    rd_new <= new_mem[rd_addr];
  end

endmodule

/* sv/tepr_csum.sv */
// Incremental checksum unit: one 16-bit word replacement per cycle,
// five steps (IP addr hi/lo, TCP addr hi/lo, TCP port). Uses tepr_pkg.
module tepr_csum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tepr_pkg::tepr_cs_req_t req,
  output tepr_pkg::tepr_cs_rsp_t rsp
);
  import tepr_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic        run_r, run_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        done_r, done_nxt;
  logic [15:0] ip_r, ip_nxt;
  logic [15:0] tcp_r, tcp_nxt;
  logic [31:0] from_addr_r, to_addr_r;
  logic [15:0] from_port_r, to_port_r;
  logic [15:0] hc, word_a, word_b, swapped;
  logic [17:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Pick the checksum and the word pair for this step
  always_comb begin
    case (step_r)
      3'd0: begin
        hc = ip_r;  word_a = from_addr_r[31:16]; word_b = to_addr_r[31:16];
      end
      3'd1: begin
        hc = ip_r;  word_a = from_addr_r[15:0];  word_b = to_addr_r[15:0];
      end
      3'd2: begin
        hc = tcp_r; word_a = from_addr_r[31:16]; word_b = to_addr_r[31:16];
      end
      3'd3: begin
        hc = tcp_r; word_a = from_addr_r[15:0];  word_b = to_addr_r[15:0];
      end
      default: begin
        hc = tcp_r; word_a = from_port_r;        word_b = to_port_r;
      end
    endcase
  end

  // HC' = ~(~HC + ~m + m') with end-around carry
  always_comb begin
    sum     = {2'b00, ~hc} + {2'b00, ~word_a} + {2'b00, word_b};
    fold1   = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
    fold2   = fold1[15:0] + {15'd0, fold1[16]};
    swapped = ~fold2;
  end

  // Step sequencing
  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    ip_nxt   = ip_r;
    tcp_nxt  = tcp_r;
    if (req.start) begin
      run_nxt  = 1'b1;
      step_nxt = 3'd0;
      ip_nxt   = req.ip_csum;
      tcp_nxt  = req.tcp_csum;
    end else if (run_r) begin
      if (step_r < 3'd2) begin
        ip_nxt = swapped;
      end else begin
        tcp_nxt = swapped;
      end
      step_nxt = step_r + 3'd1;
      if (step_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // Operands and running checksums
  always_ff @(posedge clk) begin
    ip_r  <= ip_nxt;
    tcp_r <= tcp_nxt;
    if (req.start) begin
      from_addr_r <= req.from_addr;
      from_port_r <= req.from_port;
      to_addr_r   <= req.to_addr;
      to_port_r   <= req.to_port;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.ip_csum  = ip_r;
  assign rsp.tcp_csum = tcp_r;

endmodule

/* sv/tcp_endpoint_rewrite_table_unit.sv */
// Top level of the TCP endpoint rewrite table: sequencer, entry count,
// first-match search over the store, result register. Uses tepr_pkg,
// tepr_store and tepr_csum.
//
//   channel  ports                     direction  handshake
//   input    start, busy, in_item      in         taken when start & !busy
//   result   out_valid, out_item       out        one-cycle strobe, no stall
//
// Insert: result in the cycle after the item is taken.
// Header: the search reads one stored entry per cycle through the store's
// single read port; a rewrite hit at an entry then runs the checksum
// unit's 5 steps before the result. Non-TCP items and unknown action codes
// answer in the cycle after they are taken.
// Synchronous active-low reset empties the table; store contents are
// never cleared. busy is high only while a header search or checksum runs.
module tcp_endpoint_rewrite_table_unit #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tepr_pkg::tepr_in_t  in_item,
  output logic                out_valid,
  output tepr_pkg::tepr_out_t out_item
);
  import tepr_pkg::*;

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

  tepr_state_t     state_r, state_nxt;
  tepr_in_t        req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic            pend_r, pend_nxt;
  logic [31:0]     tgt_addr_r, tgt_addr_nxt;
  logic [15:0]     tgt_port_r, tgt_port_nxt;
  logic            out_valid_r, out_valid_nxt;
  tepr_out_t       out_item_r, out_item_nxt;

  logic            wr_en;
  logic [EP_W-1:0] rd_old, rd_new;
  logic [EP_W-1:0] src_ep, dst_ep;
  logic            is_in;
  logic [CNT_W+7:0] count_ext;
  tepr_cs_req_t    cs_req;
  tepr_cs_rsp_t    cs_rsp;

  tepr_store #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_old  ({in_item.orig_addr, in_item.orig_port}),
    .wr_new  ({in_item.repl_addr, in_item.repl_port}),
    .rd_addr (k_r[ADDR_W-1:0]),
    .rd_old  (rd_old),
    .rd_new  (rd_new)
  );

  tepr_csum u_csum (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cs_req),
    .rsp   (cs_rsp)
  );

  assign src_ep = {req_r.src_addr, req_r.src_port};
  assign dst_ep = {req_r.dst_addr, req_r.dst_port};
  assign is_in  = (req_r.action == ACT_INCOMING);

  // Sequencer: insert, search, checksum, result
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    tgt_addr_nxt  = tgt_addr_r;
    tgt_port_nxt  = tgt_port_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    count_ext     = '0;

    cs_req.start     = 1'b0;
    cs_req.ip_csum   = req_r.ip_csum;
    cs_req.tcp_csum  = req_r.tcp_csum;
    cs_req.from_addr = is_in ? req_r.src_addr : req_r.dst_addr;
    cs_req.from_port = is_in ? req_r.src_port : req_r.dst_port;
    cs_req.to_addr   = is_in ? rd_old[47:16] : rd_new[47:16];
    cs_req.to_port   = is_in ? rd_old[15:0]  : rd_new[15:0];

    // Default result: the held header echoed unchanged
    out_item_nxt.verdict      = V_PASS;
    out_item_nxt.out_src_addr = req_r.src_addr;
    out_item_nxt.out_src_port = req_r.src_port;
    out_item_nxt.out_dst_addr = req_r.dst_addr;
    out_item_nxt.out_dst_port = req_r.dst_port;
    out_item_nxt.out_ip_csum  = req_r.ip_csum;
    out_item_nxt.out_tcp_csum = req_r.tcp_csum;
    count_ext                 = (CNT_W + 8)'(count_r);
    out_item_nxt.entry_total  = count_ext[7:0];

    case (state_r)
      ST_IDLE: begin
        out_item_nxt = out_item_r;
        if (start) begin
          req_nxt = in_item;
          if (in_item.action == ACT_INSERT) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            if (count_r < CNT_MAX) begin
              wr_en                = 1'b1;
              count_nxt            = count_r + CNT_W'(1);
              out_item_nxt.verdict = V_INSERTED;
            end else begin
              out_item_nxt.verdict = V_FULL;
            end
            count_ext                = (CNT_W + 8)'(count_nxt);
            out_item_nxt.entry_total = count_ext[7:0];
          end else if (in_item.is_tcp && (in_item.action == ACT_INCOMING ||
                                          in_item.action == ACT_OUTGOING)) begin
            state_nxt = ST_SEARCH;
            k_nxt     = '0;
          end else begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.verdict      = V_PASS;
            out_item_nxt.out_src_addr = in_item.src_addr;
            out_item_nxt.out_src_port = in_item.src_port;
            out_item_nxt.out_dst_addr = in_item.dst_addr;
            out_item_nxt.out_dst_port = in_item.dst_port;
            out_item_nxt.out_ip_csum  = in_item.ip_csum;
            out_item_nxt.out_tcp_csum = in_item.tcp_csum;
            out_item_nxt.entry_total  = count_ext[7:0];
          end
        end
      end

      ST_SEARCH: begin
        if (pend_r && is_in && rd_old == src_ep) begin
          // Incoming source is an old endpoint
          out_valid_nxt        = 1'b1;
          out_item_nxt.verdict = V_DROP;
          state_nxt            = ST_IDLE;
        end else if (pend_r && ((is_in && rd_new == src_ep) ||
                                (!is_in && rd_old == dst_ep))) begin
          cs_req.start = 1'b1;
          tgt_addr_nxt = cs_req.to_addr;
          tgt_port_nxt = cs_req.to_port;
          state_nxt    = ST_CSUM;
        end else if (k_r < count_r) begin
          // Issue the next entry read
          pend_nxt = 1'b1;
          k_nxt    = k_r + CNT_W'(1);
          out_item_nxt = out_item_r;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CSUM: begin
        if (cs_rsp.done) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.verdict      = V_REWRITE;
          out_item_nxt.out_ip_csum  = cs_rsp.ip_csum;
          out_item_nxt.out_tcp_csum = cs_rsp.tcp_csum;
          if (is_in) begin
            out_item_nxt.out_src_addr = tgt_addr_r;
            out_item_nxt.out_src_port = tgt_port_r;
          end else begin
            out_item_nxt.out_dst_addr = tgt_addr_r;
            out_item_nxt.out_dst_port = tgt_port_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          out_item_nxt = out_item_r;
        end
      end

      default: begin
        out_item_nxt = out_item_r;
        state_nxt    = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    tgt_addr_r <= tgt_addr_nxt;
    tgt_port_r <= tgt_port_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
